FILE: rtl/rrp_pkg.sv
// ============================================================================
// rrp_pkg: shared types and constants for the record row parser
// Phase codes, result kinds, column type codes and the parser state record.
// ============================================================================
package rrp_pkg;

    localparam int MAX_COLUMNS = 16;

    // current column counts up to MAX_COLUMNS inclusive
    localparam int COL_W = $clog2(MAX_COLUMNS + 1);
    // compare width covering both the 5-bit column_count and the column counter
    localparam int CMP_W = ((COL_W > 5) ? COL_W : 5) + 1;
    // columns whose type bits fit in the 32-bit type register
    localparam int TYPE_COLS = 16;

    localparam int CC_W   = 5;
    localparam int CT_W   = 2 * TYPE_COLS;
    localparam int CFG_W  = 32;
    localparam int BC_W   = 4;
    localparam int ACC_W  = 64;
    localparam int LEN_W  = 16;
    localparam int KIND_W = 4;
    localparam int CIDX_W = 4;

    localparam logic [BC_W-1:0] FIXED_BYTES = BC_W'(8);
    localparam logic [BC_W-1:0] LEN_BYTES   = BC_W'(2);

    // parse phases
    localparam logic [2:0] PH_TS      = 3'd0;
    localparam logic [2:0] PH_FLAG    = 3'd1;
    localparam logic [2:0] PH_FIXED   = 3'd2;
    localparam logic [2:0] PH_STRLEN  = 3'd3;
    localparam logic [2:0] PH_STRBODY = 3'd4;
    localparam logic [2:0] PH_DONE    = 3'd5;

    // result kinds
    localparam logic [KIND_W-1:0] K_TS      = 4'd0;
    localparam logic [KIND_W-1:0] K_NULL    = 4'd1;
    localparam logic [KIND_W-1:0] K_INT     = 4'd2;
    localparam logic [KIND_W-1:0] K_STRHDR  = 4'd5;
    localparam logic [KIND_W-1:0] K_STRBYTE = 4'd6;
    localparam logic [KIND_W-1:0] K_TRUNC   = 4'd7;
    localparam logic [KIND_W-1:0] K_END     = 4'd8;

    // column type codes
    localparam logic [1:0] T_STRING = 2'd3;

    // config register indexes
    localparam logic CFG_COLUMN_COUNT = 1'b0;
    localparam logic CFG_COLUMN_TYPES = 1'b1;

    typedef struct packed {
        logic [2:0]       phase;
        logic [COL_W-1:0] column;
        logic [BC_W-1:0]  byte_count;
        logic [ACC_W-1:0] acc;
        logic [LEN_W-1:0] str_remaining;
    } parse_state_t;

    // start-of-row parser state
    localparam parse_state_t ROW_START = '{phase: PH_TS, column: '0, byte_count: '0,
                                           acc: '0, str_remaining: '0};

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [CIDX_W-1:0] column_index;
        logic [ACC_W-1:0]  value;
        logic              record_end;
    } parse_result_t;

endpackage

FILE: rtl/record_row_parser.sv
// ============================================================================
// record_row_parser: streaming parser for one stored table row
// Walks a serialized row byte by byte under a configured column schema and
// emits one decoded transaction per timestamp, null, fixed value, string
// header and string byte, plus truncation and end markers at the row end.
// ============================================================================
//
//  channel | signals                                  | role
//  --------+------------------------------------------+---------------------
//  in      | in_valid, in_ready, data_byte, last_byte | record bytes
//  out     | out_valid, out_ready, kind, column_index,| decoded results
//          | value, record_end                        |
//  cfg     | cfg_we, cfg_index, cfg_data              | schema registers
//
// Throughput: one byte per cycle while out is not stalled. An accepted byte
// lands in the input register, and the parse step then loads its result
// into the result register.
// The input register advances whenever the result register is empty or is
// being drained the same cycle, so a stall on out holds the byte in flight.
// Reset clears the schema to zero columns and puts the parser at the start
// of a row; the parser returns there after every byte marked last_byte.
// Bytes past the last column produce no transaction until the row's end.
//
module record_row_parser
    import rrp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,

    output logic                out_valid,
    input  logic                out_ready,
    output logic [KIND_W-1:0]   kind,
    output logic [CIDX_W-1:0]   column_index,
    output logic [ACC_W-1:0]    value,
    output logic                record_end,

    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CFG_W-1:0]    cfg_data
);

    // schema registers
    logic [CC_W-1:0]  column_count_reg;
    logic [CT_W-1:0]  column_types_reg;

    // input register
    logic             s1_valid_reg;
    logic [7:0]       s1_byte_reg;
    logic             s1_last_reg;

    // parser state and result register
    parse_state_t     state_reg;
    parse_state_t     state_next;
    parse_result_t    step_res;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [KIND_W-1:0] kind_reg;
    logic [CIDX_W-1:0] column_index_reg;
    logic [ACC_W-1:0] value_reg;
    logic             record_end_reg;

    logic             out_slot_free;
    logic             s1_fire;
    logic             in_fire;

    // ------------------------------------------------------------------
    // configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            column_types_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_COLUMN_COUNT: column_count_reg <= cfg_data[CC_W-1:0];
                CFG_COLUMN_TYPES: column_types_reg <= cfg_data[CT_W-1:0];
                default:          column_count_reg <= column_count_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // handshake: the step fires only with room in the result register
    // ------------------------------------------------------------------
    assign out_slot_free = !out_valid_reg || out_ready;
    assign s1_fire       = s1_valid_reg && out_slot_free;
    assign in_ready      = !s1_valid_reg || s1_fire;
    assign in_fire       = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
    end

    // ------------------------------------------------------------------
    // parse step
    // ------------------------------------------------------------------
    rrp_step u_step
    (
        .cur          (state_reg),
        .data_byte    (s1_byte_reg),
        .last_byte    (s1_last_reg),
        .column_count (column_count_reg),
        .column_types (column_types_reg),
        .nxt          (state_next),
        .res          (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ROW_START;
        end
        else if (s1_fire)
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_comb
    begin
        if (s1_fire)
        begin
            out_valid_next = step_res.valid;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && step_res.valid)
        begin
            kind_reg         <= step_res.kind;
            column_index_reg <= step_res.column_index;
            value_reg        <= step_res.value;
            record_end_reg   <= step_res.record_end;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign column_index = column_index_reg;
    assign value        = value_reg;
    assign record_end   = record_end_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // a row-closing byte always leaves a result and resets the parser
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_last_reg |=> out_valid_reg && record_end_reg &&
        (state_reg.phase == PH_TS) && (state_reg.column == '0))
        else $error("row end did not produce a closing result");

    // column counter never runs past the schema limit
    a_column_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.column <= COL_W'(MAX_COLUMNS))
        else $error("column counter past limit");

    // string body is only entered with bytes left to read
    a_strbody_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_STRBODY) |-> (state_reg.str_remaining != '0))
        else $error("string body with zero remaining");

    // byte counter stays inside a fixed-width field
    a_byte_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.byte_count < FIXED_BYTES)
        else $error("field byte counter overflow");

    // a held result is never overwritten by a new step
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !s1_fire)
        else $error("step fired into a full result register");

endmodule

FILE: rtl/rrp_step.sv
// ============================================================================
// rrp_step: per-byte parse step
// Combinational next state and result for one record byte.
// ============================================================================
module rrp_step
    import rrp_pkg::*;
(
    input  parse_state_t         cur,
    input  logic [7:0]           data_byte,
    input  logic                 last_byte,
    input  logic [CC_W-1:0]      column_count,
    input  logic [CT_W-1:0]      column_types,
    output parse_state_t         nxt,
    output parse_result_t        res
);

    localparam logic [CMP_W-1:0] MAX_COLS_V = CMP_W'(MAX_COLUMNS);

    logic [CMP_W-1:0] live_cols;
    logic [CMP_W-1:0] col_ext;
    logic [CMP_W-1:0] col_inc_ext;
    logic [COL_W-1:0] col_inc;
    logic [1:0]       col_type;
    logic [BC_W-1:0]  bc_inc;
    logic [2:0]       byte_pos;
    logic [ACC_W-1:0] acc_or;
    logic [LEN_W-1:0] len_val;
    logic [LEN_W-1:0] rem_dec;
    logic [2:0]       next_col_phase;
    parse_state_t     s;
    logic             have;
    logic [KIND_W-1:0] kind;
    logic [CMP_W-1:0] rcol;
    logic [ACC_W-1:0] val;
    logic             trunc;

    always_comb
    begin
        live_cols   = (CMP_W'(column_count) > MAX_COLS_V) ? MAX_COLS_V
                                                          : CMP_W'(column_count);
        col_ext     = CMP_W'(cur.column);
        col_inc     = cur.column + COL_W'(1);
        col_inc_ext = CMP_W'(col_inc);
        next_col_phase = (col_inc_ext >= live_cols) ? PH_DONE : PH_FLAG;
        col_type    = (col_ext < CMP_W'(TYPE_COLS))
                    ? column_types[{col_ext[3:0], 1'b0} +: 2] : 2'd0;
        bc_inc      = cur.byte_count + BC_W'(1);
        // string length is two bytes, fixed fields eight
        byte_pos    = (cur.phase == PH_STRLEN) ? {2'b00, cur.byte_count[0]}
                                               : cur.byte_count[2:0];
        acc_or      = cur.acc | (ACC_W'(data_byte) << {byte_pos, 3'b000});
        len_val     = acc_or[LEN_W-1:0];
        rem_dec     = cur.str_remaining - LEN_W'(1);
    end

    always_comb
    begin
        s    = cur;
        have = 1'b0;
        kind = K_TS;
        rcol = '0;
        val  = '0;

        unique case (cur.phase)
            PH_TS:
            begin
                s.acc        = acc_or;
                s.byte_count = bc_inc;
                if (bc_inc >= FIXED_BYTES)
                begin
                    have         = 1'b1;
                    kind         = K_TS;
                    val          = acc_or;
                    s.column     = '0;
                    s.byte_count = '0;
                    s.acc        = '0;
                    s.phase      = (live_cols != '0) ? PH_FLAG : PH_DONE;
                end
            end
            PH_FLAG:
            begin
                if (col_ext >= live_cols)
                begin
                    s.phase = PH_DONE;
                end
                else if (data_byte != 8'd0)
                begin
                    have         = 1'b1;
                    kind         = K_NULL;
                    rcol         = col_ext;
                    s.column     = col_inc;
                    s.phase      = next_col_phase;
                    s.byte_count = '0;
                    s.acc        = '0;
                end
                else
                begin
                    s.phase      = (col_type == T_STRING) ? PH_STRLEN : PH_FIXED;
                    s.byte_count = '0;
                    s.acc        = '0;
                end
            end
            PH_FIXED:
            begin
                s.acc        = acc_or;
                s.byte_count = bc_inc;
                if (bc_inc >= FIXED_BYTES)
                begin
                    have         = 1'b1;
                    rcol         = col_ext;
                    val          = acc_or;
                    // a string type here (changed mid-field) reports as int
                    kind         = (col_type == T_STRING) ? K_INT
                                 : K_INT + KIND_W'(col_type);
                    s.column     = col_inc;
                    s.phase      = next_col_phase;
                    s.byte_count = '0;
                    s.acc        = '0;
                end
            end
            PH_STRLEN:
            begin
                s.acc        = acc_or;
                s.byte_count = bc_inc;
                if (bc_inc >= LEN_BYTES)
                begin
                    have            = 1'b1;
                    kind            = K_STRHDR;
                    rcol            = col_ext;
                    val             = ACC_W'(len_val);
                    s.str_remaining = len_val;
                    s.byte_count    = '0;
                    s.acc           = '0;
                    if (len_val == '0)
                    begin
                        s.column = col_inc;
                        s.phase  = next_col_phase;
                    end
                    else
                    begin
                        s.phase = PH_STRBODY;
                    end
                end
            end
            PH_STRBODY:
            begin
                have            = 1'b1;
                kind            = K_STRBYTE;
                rcol            = col_ext;
                val             = ACC_W'(data_byte);
                s.str_remaining = rem_dec;
                if (rem_dec == '0)
                begin
                    s.column     = col_inc;
                    s.phase      = next_col_phase;
                    s.byte_count = '0;
                    s.acc        = '0;
                end
            end
            default:
            begin
                s.phase = PH_DONE;
            end
        endcase

        trunc = (s.phase == PH_FIXED) || (s.phase == PH_STRLEN) ||
                (s.phase == PH_STRBODY) ||
                ((s.phase == PH_TS) && (s.byte_count != '0));

        res.record_end = last_byte;
        if (last_byte)
        begin
            res.valid = 1'b1;
            if (trunc)
            begin
                res.kind         = K_TRUNC;
                res.column_index = (s.phase == PH_TS) ? '0 : s.column[CIDX_W-1:0];
                res.value        = '0;
            end
            else if (!have)
            begin
                res.kind         = K_END;
                res.column_index = '0;
                res.value        = '0;
            end
            else
            begin
                res.kind         = kind;
                res.column_index = rcol[CIDX_W-1:0];
                res.value        = val;
            end
            // row closed: back to the start-of-row state
            nxt               = '0;
            nxt.phase         = PH_TS;
        end
        else
        begin
            res.valid        = have;
            res.kind         = kind;
            res.column_index = rcol[CIDX_W-1:0];
            res.value        = val;
            nxt              = s;
        end
    end

endmodule

FILE: verif/record_row_parser_tb.sv
// ============================================================================
// record_row_parser_tb: self-checking testbench for the record row parser
// Feeds serialized rows byte by byte under several column schemas, decodes
// every accepted byte in a local parser model, and compares each output
// transaction field by field against the oldest decoded result.
// ============================================================================
module record_row_parser_tb;
    import rrp_pkg::*;

    // column type codes beyond the one the package provides
    localparam logic [1:0] T_INT      = 2'd0;
    localparam logic [1:0] T_DECIMAL  = 2'd1;
    localparam logic [1:0] T_DATETIME = 2'd2;

    localparam int CLK_HALF   = 6;
    localparam int SETTLE_CYC = 4;     // pipeline depth plus margin

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CIDX_W-1:0] column_index;
        logic [ACC_W-1:0]  value;
        logic              record_end;
    } row_result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         data_byte;
    logic               last_byte;
    logic               out_valid;
    logic               out_ready;
    logic [KIND_W-1:0]  kind;
    logic [CIDX_W-1:0]  column_index;
    logic [ACC_W-1:0]   value;
    logic               record_end;
    logic               cfg_we;
    logic               cfg_index;
    logic [CFG_W-1:0]   cfg_data;

    record_row_parser DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .column_index (column_index),
        .value        (value),
        .record_end   (record_end),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // ------------------------------------------------------------------
    // Local parser model: schema mirror, parse state, decoded results
    // ------------------------------------------------------------------
    logic [CC_W-1:0]   schema_count;
    logic [CT_W-1:0]   schema_types;
    logic [2:0]        prs_phase;
    int                prs_col;
    int                prs_nbytes;
    logic [ACC_W-1:0]  prs_acc;
    logic [LEN_W-1:0]  prs_str_left;

    row_result_t       decoded_fifo[$];
    int                mismatches;

    // traffic shaping knobs
    bit                src_idle;
    bit                sink_idle;
    int                sink_hold;

    function automatic int live_cols();
        return (schema_count > MAX_COLUMNS) ? MAX_COLUMNS : int'(schema_count);
    endfunction

    // columns past the type register read as int
    function automatic logic [1:0] col_type(input int c);
        return (c >= TYPE_COLS) ? T_INT : schema_types[2*c +: 2];
    endfunction

    function automatic void clear_parse();
        prs_phase    = PH_TS;
        prs_col      = 0;
        prs_nbytes   = 0;
        prs_acc      = '0;
        prs_str_left = '0;
    endfunction

    function automatic void advance_column();
        prs_col++;
        prs_phase  = (prs_col >= live_cols()) ? PH_DONE : PH_FLAG;
        prs_nbytes = 0;
        prs_acc    = '0;
    endfunction

    // Decode one accepted byte; queue the result it yields, if any.
    function automatic void decode_row_byte(input logic [7:0] b, input logic last);
        row_result_t r;
        logic        have;
        logic [1:0]  t;
        r    = '0;
        have = 1'b0;
        case (prs_phase)
            PH_TS:
            begin
                prs_acc |= ACC_W'(b) << (8 * prs_nbytes);
                prs_nbytes++;
                if (prs_nbytes >= 8)
                begin
                    have       = 1'b1;
                    r.kind     = K_TS;
                    r.value    = prs_acc;
                    prs_col    = 0;
                    prs_nbytes = 0;
                    prs_acc    = '0;
                    prs_phase  = (live_cols() != 0) ? PH_FLAG : PH_DONE;
                end
            end
            PH_FLAG:
            begin
                if (prs_col >= live_cols())
                    prs_phase = PH_DONE;
                else if (b != 8'd0)
                begin
                    have           = 1'b1;
                    r.kind         = K_NULL;
                    r.column_index = CIDX_W'(prs_col);
                    advance_column();
                end
                else
                begin
                    prs_phase  = (col_type(prs_col) == T_STRING) ? PH_STRLEN : PH_FIXED;
                    prs_nbytes = 0;
                    prs_acc    = '0;
                end
            end
            PH_FIXED:
            begin
                prs_acc |= ACC_W'(b) << (8 * prs_nbytes);
                prs_nbytes++;
                if (prs_nbytes >= 8)
                begin
                    t              = col_type(prs_col);
                    have           = 1'b1;
                    r.column_index = CIDX_W'(prs_col);
                    r.value        = prs_acc;
                    // a column retyped to string mid-value still reports as int
                    r.kind = (t == T_STRING) ? K_INT : K_INT + KIND_W'(t);
                    advance_column();
                end
            end
            PH_STRLEN:
            begin
                prs_acc |= ACC_W'(b) << (8 * (prs_nbytes & 1));
                prs_nbytes++;
                if (prs_nbytes >= 2)
                begin
                    prs_str_left   = prs_acc[LEN_W-1:0];
                    have           = 1'b1;
                    r.kind         = K_STRHDR;
                    r.column_index = CIDX_W'(prs_col);
                    r.value        = ACC_W'(prs_str_left);
                    if (prs_str_left == '0)
                        advance_column();
                    else
                    begin
                        prs_phase  = PH_STRBODY;
                        prs_nbytes = 0;
                        prs_acc    = '0;
                    end
                end
            end
            PH_STRBODY:
            begin
                have           = 1'b1;
                r.kind         = K_STRBYTE;
                r.column_index = CIDX_W'(prs_col);
                r.value        = ACC_W'(b);
                prs_str_left   = prs_str_left - 1'b1;
                if (prs_str_left == '0)
                    advance_column();
            end
            default:
                prs_phase = PH_DONE;
        endcase

        if (last)
        begin
            // row closed inside a field: report truncation instead
            if (prs_phase == PH_FIXED || prs_phase == PH_STRLEN ||
                prs_phase == PH_STRBODY || (prs_phase == PH_TS && prs_nbytes > 0))
            begin
                r.kind         = K_TRUNC;
                r.column_index = (prs_phase == PH_TS) ? '0 : CIDX_W'(prs_col);
                r.value        = '0;
            end
            else if (!have)
            begin
                r.kind         = K_END;
                r.column_index = '0;
                r.value        = '0;
            end
            r.record_end = 1'b1;
            decoded_fifo = {decoded_fifo, r};
            clear_parse();
        end
        else if (have)
            decoded_fifo = {decoded_fifo, r};
    endfunction

    // ------------------------------------------------------------------
    // Clock, timeout
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    // hard stop; far beyond the slowest legal run
    initial
    begin
        #(2 * CLK_HALF * 400000);
        $display("record_row_parser: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: drives out_ready on the falling edge. A long hold-off
    // (sink_hold) takes priority over the random stall bursts.
    // ------------------------------------------------------------------
    initial
    begin
        int stall;
        out_ready = 1'b0;
        stall     = 0;
        forever
        begin
            @(negedge clk);
            if (sink_hold > 0)
            begin
                out_ready = 1'b0;
                sink_hold--;
            end
            else if (stall > 0)
            begin
                out_ready = 1'b0;
                stall--;
            end
            else if (sink_idle && $urandom_range(0, 5) == 0)
            begin
                out_ready = 1'b0;
                stall     = $urandom_range(0, 2);
            end
            else
                out_ready = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Checker: every output transaction is matched against the oldest
    // decoded result. Sampled at the rising edge, before register updates.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        row_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (decoded_fifo.size() == 0)
            begin
                $error("unexpected transaction: kind %0d column %0d value %h",
                       kind, column_index, value);
                mismatches++;
            end
            else
            begin
                want = decoded_fifo.pop_front();
                if (kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, kind);
                    mismatches++;
                end
                if (column_index !== want.column_index)
                begin
                    $error("column_index: expected %0d, got %0d",
                           want.column_index, column_index);
                    mismatches++;
                end
                if (value !== want.value)
                begin
                    $error("value: expected %h, got %h", want.value, value);
                    mismatches++;
                end
                if (record_end !== want.record_end)
                begin
                    $error("record_end: expected %0b, got %0b",
                           want.record_end, record_end);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // One input transaction: optional idle burst, then hold valid and the
    // payload until the block takes it; decode on acceptance.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        @(negedge clk);
        if (src_idle && $urandom_range(0, 4) == 0)
        begin
            gap      = $urandom_range(1, 3);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  = 1'b1;
        data_byte = b;
        last_byte = last;
        do
            @(posedge clk);
        while (!in_ready);
        decode_row_byte(b, last);
    endtask

    // last_byte rides on the final byte of the row
    task automatic send_row(input logic [7:0] row[$]);
        int i;
        for (i = 0; i < row.size(); i++)
            send_byte(row[i], i == row.size() - 1);
    endtask

    // Drop valid, wait for every decoded result, then let the pipeline
    // flush bytes that produce nothing.
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        wait (decoded_fifo.size() == 0);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // only called with the block idle
    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        if (idx == CFG_COLUMN_COUNT)
            schema_count = data[CC_W-1:0];
        else
            schema_types = data[CT_W-1:0];
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // tack one byte onto the end of a row
    function automatic void append_byte(ref logic [7:0] row[$], input logic [7:0] b);
        row = {row, b};
    endfunction

    function automatic void put_le(ref logic [7:0] row[$], input logic [63:0] v,
                                   input int n);
        int i;
        for (i = 0; i < n; i++)
            append_byte(row, v[8*i +: 8]);
    endfunction

    // Random row for the current schema: mostly well formed with random
    // content; some rows cut short, some with trailing junk, some pure noise.
    function automatic void build_row(ref logic [7:0] row[$]);
        int  c;
        int  len;
        int  n;
        bit  open_end;
        row      = {};
        open_end = 1'b0;
        if ($urandom_range(0, 19) == 0)
        begin
            n = $urandom_range(1, 20);
            repeat (n) append_byte(row, 8'($urandom));
            return;
        end
        repeat (8) append_byte(row, 8'($urandom));
        for (c = 0; c < live_cols(); c++)
        begin
            if ($urandom_range(0, 3) == 0)
                append_byte(row, 8'($urandom_range(1, 255)));
            else
            begin
                append_byte(row, 8'd0);
                if (col_type(c) != T_STRING)
                    repeat (8) append_byte(row, 8'($urandom));
                else if ($urandom_range(0, 19) == 0)
                begin
                    // huge length: send a few body bytes and close the row early
                    len = $urandom_range(25, 65535);
                    put_le(row, 64'(len), 2);
                    repeat ($urandom_range(0, 8)) append_byte(row, 8'($urandom));
                    open_end = 1'b1;
                    break;
                end
                else
                begin
                    len = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 24)
                                                      : $urandom_range(0, 6);
                    put_le(row, 64'(len), 2);
                    repeat (len) append_byte(row, 8'($urandom));
                end
            end
        end
        if (!open_end && $urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3)) append_byte(row, 8'($urandom));
        if (!open_end && $urandom_range(0, 4) == 0)
        begin
            n = $urandom_range(1, row.size());
            while (row.size() > n)
                void'(row.pop_back());
        end
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset schema has no columns: timestamp only, rest ignored.
    task automatic test_zero_columns();
        logic [7:0] row[$];
        row = {};
        put_le(row, 64'hFFFF_FFFF_FFFF_FFFF, 8);
        append_byte(row, 8'h00);
        append_byte(row, 8'hFF);            // trailing bytes -> end only
        send_row(row);
        row = {};
        put_le(row, 64'h0, 8);              // row ends exactly on timestamp
        send_row(row);
        row = {8'h12, 8'h34, 8'h56};        // row ends inside timestamp
        send_row(row);
        drain();
    endtask

    // One column of each type, full values and nulls.
    task automatic test_column_types();
        logic [7:0] row[$];
        write_reg(CFG_COLUMN_COUNT, 32'd4);
        write_reg(CFG_COLUMN_TYPES, {24'd0, T_STRING, T_DATETIME, T_DECIMAL, T_INT});
        row = {};
        put_le(row, 64'h8000_0000_0000_0001, 8);
        append_byte(row, 8'h00);
        put_le(row, 64'hFFFF_FFFF_FFFF_FFFF, 8);
        append_byte(row, 8'h00);
        put_le(row, 64'h0123_4567_89AB_CDEF, 8);
        append_byte(row, 8'h00);
        put_le(row, 64'h0, 8);
        append_byte(row, 8'h00);
        put_le(row, 64'h2, 2);
        append_byte(row, 8'h00);
        append_byte(row, 8'hFF);            // row ends on a column boundary
        send_row(row);
        // all nulls, empty string, then an ignored trailing byte
        row = {};
        put_le(row, 64'h7F, 8);
        append_byte(row, 8'hFF);
        append_byte(row, 8'h01);
        append_byte(row, 8'h80);
        append_byte(row, 8'h00);
        put_le(row, 64'h0, 2);
        append_byte(row, 8'h7F);
        send_row(row);
        drain();
    endtask

    // Rows closed inside each kind of field, and on a null flag.
    task automatic test_truncation();
        logic [7:0] row[$];
        row = {};
        put_le(row, 64'h1, 8);
        append_byte(row, 8'h00);
        put_le(row, 64'hAA_BB_CC, 3);       // inside an int value
        send_row(row);
        row = {};
        put_le(row, 64'h2, 8);
        append_byte(row, 8'h01);            // null ends the row cleanly
        send_row(row);
        row = {};
        put_le(row, 64'h3, 8);
        append_byte(row, 8'h01);
        append_byte(row, 8'h01);
        append_byte(row, 8'h01);
        append_byte(row, 8'h00);            // zero null flag closes the row
        send_row(row);
        row = {};
        put_le(row, 64'h4, 8);
        append_byte(row, 8'h01);
        append_byte(row, 8'h01);
        append_byte(row, 8'h01);
        append_byte(row, 8'h00);
        append_byte(row, 8'h03);            // inside the string length
        send_row(row);
        row = {};
        put_le(row, 64'h5, 8);
        append_byte(row, 8'h01);
        append_byte(row, 8'h01);
        append_byte(row, 8'h01);
        append_byte(row, 8'h00);
        put_le(row, 64'h3, 2);
        append_byte(row, 8'h5A);            // inside the string body
        send_row(row);
        drain();
    endtask

    // Schema changes while a row is open take effect at once.
    task automatic test_config_midrow();
        int i;
        // shrink column count: next null flag finds the row finished
        write_reg(CFG_COLUMN_COUNT, 32'd3);
        write_reg(CFG_COLUMN_TYPES, 32'd0);
        for (i = 0; i < 8; i++)
            send_byte(8'(i), 1'b0);
        send_byte(8'h01, 1'b0);
        drain();
        write_reg(CFG_COLUMN_COUNT, 32'd1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h55, 1'b1);
        drain();
        // retype column 1 to string before its flag
        write_reg(CFG_COLUMN_COUNT, 32'd2);
        for (i = 0; i < 8; i++)
            send_byte(8'(8'hF0 + i), 1'b0);
        send_byte(8'h01, 1'b0);
        drain();
        write_reg(CFG_COLUMN_TYPES, {28'd0, T_STRING, T_INT});
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h99, 1'b1);
        drain();
        // retype an int column to string while its value is in progress
        write_reg(CFG_COLUMN_COUNT, 32'd1);
        write_reg(CFG_COLUMN_TYPES, 32'd0);
        for (i = 0; i < 8; i++)
            send_byte(8'h11, 1'b0);
        send_byte(8'h00, 1'b0);
        for (i = 0; i < 3; i++)
            send_byte(8'h22, 1'b0);
        drain();
        write_reg(CFG_COLUMN_TYPES, {30'd0, T_STRING});
        for (i = 0; i < 5; i++)
            send_byte(8'h33, i == 4);
        drain();
    endtask

    // Random rows under a series of schemas, extremes included.
    task automatic test_random_rows();
        logic [7:0] row[$];
        int         setting;
        int         sent;
        for (setting = 0; setting < 6; setting++)
        begin
            case (setting)
                0:
                begin
                    write_reg(CFG_COLUMN_COUNT, 32'($urandom_range(1, 6)));
                    write_reg(CFG_COLUMN_TYPES, $urandom);
                end
                1:
                begin
                    write_reg(CFG_COLUMN_COUNT, 32'd16);
                    write_reg(CFG_COLUMN_TYPES, 32'hFFFF_FFFF);
                end
                2:
                begin
                    // count above the maximum acts as the maximum
                    write_reg(CFG_COLUMN_COUNT, 32'd31);
                    write_reg(CFG_COLUMN_TYPES, 32'd0);
                end
                3:
                begin
                    // upper data bits are not part of the count
                    write_reg(CFG_COLUMN_COUNT, {27'($urandom), 5'd0});
                    write_reg(CFG_COLUMN_TYPES, $urandom);
                end
                4:
                begin
                    write_reg(CFG_COLUMN_COUNT, {27'($urandom), 5'd1});
                    write_reg(CFG_COLUMN_TYPES, $urandom);
                end
                default:
                begin
                    write_reg(CFG_COLUMN_COUNT, 32'($urandom_range(0, 31)));
                    write_reg(CFG_COLUMN_TYPES, $urandom);
                end
            endcase
            sent = 0;
            while (sent < 16)
            begin
                build_row(row);
                send_row(row);
                sent += row.size();
            end
            drain();
        end
    endtask

    // Receiver holds off for a long stretch while the sender keeps
    // offering bytes; the block must fill and stall its input.
    task automatic test_backpressure();
        logic [7:0] row[$];
        int         c;
        src_idle = 1'b0;
        write_reg(CFG_COLUMN_COUNT, 32'd4);
        write_reg(CFG_COLUMN_TYPES, 32'h0000_00FF);
        row = {};
        put_le(row, {$urandom, $urandom}, 8);
        for (c = 0; c < 4; c++)
        begin
            append_byte(row, 8'h00);
            put_le(row, 64'd6, 2);
            put_le(row, {$urandom, $urandom}, 6);
        end
        sink_hold = 60;
        send_row(row);
        drain();
        src_idle = 1'b1;
    endtask

    // Closing stretch with no idling on either side.
    task automatic test_steady_stream();
        logic [7:0] row[$];
        int         sent;
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        write_reg(CFG_COLUMN_COUNT, 32'($urandom_range(2, 5)));
        write_reg(CFG_COLUMN_TYPES, $urandom);
        sent = 0;
        while (sent < 30)
        begin
            build_row(row);
            send_row(row);
            sent += row.size();
        end
        drain();
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        data_byte    = 8'd0;
        last_byte    = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_COLUMN_COUNT;
        cfg_data     = '0;
        schema_count = '0;
        schema_types = '0;
        mismatches   = 0;
        src_idle     = 1'b1;
        sink_idle    = 1'b1;
        sink_hold    = 0;
        clear_parse();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_zero_columns();
        test_column_types();
        test_truncation();
        test_config_midrow();
        test_random_rows();
        test_backpressure();
        test_steady_stream();

        if (mismatches == 0)
            $display("record_row_parser: match");
        else
            $display("record_row_parser: mismatch");
        $finish;
    end

endmodule
